/* rtl/assert_macros.svh */
// Assertion macros shared by the lexer RTL.
// KOL_ASSERT checks a property on every rising clock edge outside reset.
// KOL_NEVER checks that an expression never holds outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KOL_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define KOL_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define KOL_ASSERT(name, clk, rst_n, prop)
`define KOL_NEVER(name, clk, rst_n, expr)
`endif
`endif

/* rtl/kol_pkg.sv */
package kol_pkg;

    // Sizes
    localparam int MAX_IDENT_DEF  = 32;
    localparam int WINDOW_BYTES   = 9;
    localparam int MAX_RESULTS    = 48;
    localparam int CMDQ_DEPTH_DEF = 4;
    localparam int RCNT_W         = $clog2(MAX_RESULTS + 1);

    // Characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Token kinds
    localparam logic [5:0] TK_IDENT    = 6'd0;
    localparam logic [5:0] TK_FN       = 6'd1;
    localparam logic [5:0] TK_VAR      = 6'd2;
    localparam logic [5:0] TK_STRUCT   = 6'd3;
    localparam logic [5:0] TK_ENUM     = 6'd4;
    localparam logic [5:0] TK_SEMI     = 6'd6;
    localparam logic [5:0] TK_COLON    = 6'd7;
    localparam logic [5:0] TK_COMMA    = 6'd8;
    localparam logic [5:0] TK_DOT      = 6'd9;
    localparam logic [5:0] TK_IF       = 6'd10;
    localparam logic [5:0] TK_ELSE     = 6'd11;
    localparam logic [5:0] TK_LOOP     = 6'd12;
    localparam logic [5:0] TK_WHILE    = 6'd13;
    localparam logic [5:0] TK_RETURN   = 6'd15;
    localparam logic [5:0] TK_BREAK    = 6'd16;
    localparam logic [5:0] TK_CONTINUE = 6'd17;
    localparam logic [5:0] TK_LPAREN   = 6'd18;
    localparam logic [5:0] TK_RPAREN   = 6'd19;
    localparam logic [5:0] TK_LBRACE   = 6'd20;
    localparam logic [5:0] TK_RBRACE   = 6'd21;
    localparam logic [5:0] TK_LSQUARE  = 6'd22;
    localparam logic [5:0] TK_RSQUARE  = 6'd23;
    localparam logic [5:0] TK_RANGE    = 6'd24;
    localparam logic [5:0] TK_ASSIGN   = 6'd25;
    localparam logic [5:0] TK_LESS     = 6'd27;
    localparam logic [5:0] TK_GREATER  = 6'd29;
    localparam logic [5:0] TK_ADD      = 6'd31;
    localparam logic [5:0] TK_SUB      = 6'd33;
    localparam logic [5:0] TK_MUL      = 6'd35;
    localparam logic [5:0] TK_DIV      = 6'd37;
    localparam logic [5:0] TK_MOD      = 6'd39;
    localparam logic [5:0] TK_NOT      = 6'd41;

    // Commands from the classifier to the emitter
    localparam logic [1:0] CMD_NOP        = 2'd0;
    localparam logic [1:0] CMD_PUSH       = 2'd1;
    localparam logic [1:0] CMD_PUSH_FLUSH = 2'd2;
    localparam logic [1:0] CMD_TOKEN      = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;      // character, or token kind in the low bits
        logic       step_end;  // last command of one input word
        logic       drop;      // end of text: discard the buffer afterward
    } cmd_t;

endpackage

/* rtl/keyword_operator_lexer_top.sv */
// Channel  | Handshake            | Word
// ---------+----------------------+--------------------------------------------------
// input    | push / full          | source_byte, end_of_text
// result   | pop / empty          | token_kind, char_value, ident_end, truncated,
//          |                      | run_last
//
// Once its 9-byte window is full, the front takes one byte per cycle unless the
// command queue is full, and issues at most one command per byte; an end_of_text byte
// drains the window, one byte a cycle while the queue has room. The back pops each
// command, reads from the buffer then outputs each flushed identifier character,
// emits tokens and closes each byte's run of results. Reset is asynchronous, active
// low, and clears all control state; the identifier buffer needs no clearing pass. A
// full command queue stalls the front, and a waiting result stalls the back only; the
// result register takes new words while the previous one is being popped.
module keyword_operator_lexer_top #(
    parameter int MAX_IDENT  = kol_pkg::MAX_IDENT_DEF,
    parameter int CMDQ_DEPTH = kol_pkg::CMDQ_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] source_byte,
    input  logic       end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [5:0] token_kind,
    output logic [7:0] char_value,
    output logic       ident_end,
    output logic       truncated,
    output logic       run_last
);

    kol_pkg::cmd_t front_cmd;
    kol_pkg::cmd_t back_cmd;
    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_pop;
    logic          cmd_empty;

    kol_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .source_byte (source_byte),
        .end_of_text (end_of_text),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd         (front_cmd)
    );

    kol_cmd_fifo #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    kol_back #(
        .MAX_IDENT (MAX_IDENT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .cmd        (back_cmd),
        .empty      (empty),
        .pop        (pop),
        .token_kind (token_kind),
        .char_value (char_value),
        .ident_end  (ident_end),
        .truncated  (truncated),
        .run_last   (run_last)
    );

endmodule

/* rtl/kol_front.sv */
module kol_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    source_byte,
    input  logic          end_of_text,
    input  logic          cmd_full,
    output logic          cmd_push,
    output kol_pkg::cmd_t cmd
);

    localparam logic F_IDLE  = 1'b0;
    localparam logic F_DRAIN = 1'b1;

    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_C = 8'h63;
    localparam logic [7:0] CH_E = 8'h65;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_I = 8'h69;
    localparam logic [7:0] CH_L = 8'h6C;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_V = 8'h76;
    localparam logic [7:0] CH_W = 8'h77;

    // Keywords, first letter in the top byte
    localparam logic [63:0] KW_FN       = {"fn", 48'd0};
    localparam logic [63:0] KW_VAR      = {"var", 40'd0};
    localparam logic [63:0] KW_STRUCT   = {"struct", 16'd0};
    localparam logic [63:0] KW_IF       = {"if", 48'd0};
    localparam logic [63:0] KW_ENUM     = {"enum", 32'd0};
    localparam logic [63:0] KW_ELSE     = {"else", 32'd0};
    localparam logic [63:0] KW_LOOP     = {"loop", 32'd0};
    localparam logic [63:0] KW_WHILE    = {"while", 24'd0};
    localparam logic [63:0] KW_RETURN   = {"return", 16'd0};
    localparam logic [63:0] KW_BREAK    = {"break", 24'd0};
    localparam logic [63:0] KW_CONTINUE = "continue";

    function automatic logic is_space(input logic [7:0] c);
        return (c == kol_pkg::CH_SPACE) || (c >= kol_pkg::CH_TAB && c <= kol_pkg::CH_CR);
    endfunction

    // Letters after the first match, byte n is present and is a delimiter
    function automatic logic kw_hit(input logic [8:0][7:0] w, input logic [3:0] fill,
                                    input logic [63:0] word, input logic [3:0] n,
                                    input logic alt_en, input logic [7:0] alt);
        logic       hit;
        logic [7:0] d;
        hit = fill > n;
        for (int k = 1; k < 8; k++) begin
            if (k < int'(n) && w[k] != word[63 - 8 * k -: 8])
                hit = 1'b0;
        end
        d = w[n];
        return hit && (is_space(d) || (alt_en && d == alt));
    endfunction

    logic            state_reg, state_next;
    logic [8:0][7:0] win_reg, win_next;
    logic [3:0]      fill_reg, fill_next;
    logic [3:0]      skip_reg, skip_next;
    logic            comment_reg, comment_next;
    logic            nonempty_reg, nonempty_next;
    logic            string_reg, string_next;

    logic [8:0][7:0] cw;
    logic [3:0]      cfill;
    logic            accept;
    logic            proc;
    logic            final_front;

    logic [1:0]      k_op;
    logic [7:0]      k_data;
    logic [3:0]      k_skip;
    logic            k_comment;
    logic            k_nonempty;
    logic            k_string;

    // Pick the window the classifier sees: when idle, the incoming byte tops a full window
    always_comb
    begin
        cw    = win_reg;
        cfill = fill_reg;
        if (state_reg == F_IDLE)
        begin
            cw[8] = source_byte;
            cfill = 4'd9;
        end
    end

    // Classify the front byte
    always_comb
    begin
        logic [7:0] c;
        logic       nxt;
        logic       eq;
        logic       kind_hit;
        logic [5:0] kind;
        logic [3:0] extra;
        logic       start_comment;

        c             = cw[0];
        nxt           = cfill > 4'd1;
        eq            = nxt && (cw[1] == kol_pkg::CH_EQ);
        kind_hit      = 1'b0;
        kind          = kol_pkg::TK_IDENT;
        extra         = 4'd0;
        start_comment = 1'b0;

        k_op       = kol_pkg::CMD_NOP;
        k_data     = 8'd0;
        k_skip     = skip_reg;
        k_comment  = comment_reg;
        k_nonempty = nonempty_reg;
        k_string   = string_reg;

        if (skip_reg != 4'd0)
        begin
            k_skip = skip_reg - 4'd1;
        end
        else if (comment_reg)
        begin
            if (c == kol_pkg::CH_NL)
                k_comment = 1'b0;
        end
        else if (nonempty_reg && string_reg)
        begin
            k_data = c;
            if (c == kol_pkg::CH_QUOTE)
            begin
                k_op       = kol_pkg::CMD_PUSH_FLUSH;
                k_nonempty = 1'b0;
                k_string   = 1'b0;
            end
            else
            begin
                k_op = kol_pkg::CMD_PUSH;
            end
        end
        else
        begin
            case (c)
                kol_pkg::CH_EQ:
                begin
                    kind_hit = 1'b1; kind = kol_pkg::TK_ASSIGN + {5'd0, eq};
                    extra = {3'd0, eq};
                end
                kol_pkg::CH_LT:
                begin
                    kind_hit = 1'b1; kind = kol_pkg::TK_LESS + {5'd0, eq};
                    extra = {3'd0, eq};
                end
                kol_pkg::CH_GT:
                begin
                    kind_hit = 1'b1; kind = kol_pkg::TK_GREATER + {5'd0, eq};
                    extra = {3'd0, eq};
                end
                kol_pkg::CH_PLUS:
                begin
                    kind_hit = 1'b1; kind = kol_pkg::TK_ADD + {5'd0, eq};
                    extra = {3'd0, eq};
                end
                kol_pkg::CH_MINUS:
                begin
                    kind_hit = 1'b1; kind = kol_pkg::TK_SUB + {5'd0, eq};
                    extra = {3'd0, eq};
                end
                kol_pkg::CH_STAR:
                begin
                    kind_hit = 1'b1; kind = kol_pkg::TK_MUL + {5'd0, eq};
                    extra = {3'd0, eq};
                end
                kol_pkg::CH_PCT:
                begin
                    kind_hit = 1'b1; kind = kol_pkg::TK_MOD + {5'd0, eq};
                    extra = {3'd0, eq};
                end
                kol_pkg::CH_BANG:
                begin
                    kind_hit = 1'b1; kind = kol_pkg::TK_NOT + {5'd0, eq};
                    extra = {3'd0, eq};
                end
                kol_pkg::CH_SLASH:
                begin
                    if (nxt && cw[1] == kol_pkg::CH_SLASH)
                    begin
                        start_comment = 1'b1;
                    end
                    else
                    begin
                        kind_hit = 1'b1; kind = kol_pkg::TK_DIV + {5'd0, eq};
                        extra = {3'd0, eq};
                    end
                end
                kol_pkg::CH_LPAREN: begin kind_hit = 1'b1; kind = kol_pkg::TK_LPAREN; end
                kol_pkg::CH_RPAREN: begin kind_hit = 1'b1; kind = kol_pkg::TK_RPAREN; end
                kol_pkg::CH_LBRACE: begin kind_hit = 1'b1; kind = kol_pkg::TK_LBRACE; end
                kol_pkg::CH_RBRACE: begin kind_hit = 1'b1; kind = kol_pkg::TK_RBRACE; end
                kol_pkg::CH_LSQ:    begin kind_hit = 1'b1; kind = kol_pkg::TK_LSQUARE; end
                kol_pkg::CH_RSQ:    begin kind_hit = 1'b1; kind = kol_pkg::TK_RSQUARE; end
                kol_pkg::CH_SEMI:   begin kind_hit = 1'b1; kind = kol_pkg::TK_SEMI; end
                kol_pkg::CH_COLON:  begin kind_hit = 1'b1; kind = kol_pkg::TK_COLON; end
                kol_pkg::CH_COMMA:  begin kind_hit = 1'b1; kind = kol_pkg::TK_COMMA; end
                kol_pkg::CH_DOT:
                begin
                    kind_hit = 1'b1;
                    if (nxt && cw[1] == kol_pkg::CH_DOT)
                    begin
                        kind  = kol_pkg::TK_RANGE;
                        extra = 4'd1;
                    end
                    else
                    begin
                        kind = kol_pkg::TK_DOT;
                    end
                end
                CH_V:
                    if (kw_hit(cw, cfill, KW_VAR, 4'd3, 1'b0, kol_pkg::CH_SPACE))
                    begin
                        kind_hit = 1'b1; kind = kol_pkg::TK_VAR; extra = 4'd3;
                    end
                CH_S:
                    if (kw_hit(cw, cfill, KW_STRUCT, 4'd6, 1'b0, kol_pkg::CH_SPACE))
                    begin
                        kind_hit = 1'b1; kind = kol_pkg::TK_STRUCT; extra = 4'd6;
                    end
                CH_I:
                    if (kw_hit(cw, cfill, KW_IF, 4'd2, 1'b0, kol_pkg::CH_SPACE))
                    begin
                        kind_hit = 1'b1; kind = kol_pkg::TK_IF; extra = 4'd2;
                    end
                CH_E:
                    if (kw_hit(cw, cfill, KW_ENUM, 4'd4, 1'b0, kol_pkg::CH_SPACE))
                    begin
                        kind_hit = 1'b1; kind = kol_pkg::TK_ENUM; extra = 4'd4;
                    end
                    else if (kw_hit(cw, cfill, KW_ELSE, 4'd4, 1'b0, kol_pkg::CH_SPACE))
                    begin
                        kind_hit = 1'b1; kind = kol_pkg::TK_ELSE; extra = 4'd4;
                    end
                CH_L:
                    if (kw_hit(cw, cfill, KW_LOOP, 4'd4, 1'b1, kol_pkg::CH_LBRACE))
                    begin
                        kind_hit = 1'b1; kind = kol_pkg::TK_LOOP; extra = 4'd3;
                    end
                CH_W:
                    if (kw_hit(cw, cfill, KW_WHILE, 4'd5, 1'b0, kol_pkg::CH_SPACE))
                    begin
                        kind_hit = 1'b1; kind = kol_pkg::TK_WHILE; extra = 4'd5;
                    end
                CH_F:
                    if (kw_hit(cw, cfill, KW_FN, 4'd2, 1'b0, kol_pkg::CH_SPACE))
                    begin
                        kind_hit = 1'b1; kind = kol_pkg::TK_FN; extra = 4'd2;
                    end
                CH_R:
                    if (kw_hit(cw, cfill, KW_RETURN, 4'd6, 1'b1, kol_pkg::CH_SEMI))
                    begin
                        kind_hit = 1'b1; kind = kol_pkg::TK_RETURN; extra = 4'd5;
                    end
                CH_B:
                    if (kw_hit(cw, cfill, KW_BREAK, 4'd5, 1'b1, kol_pkg::CH_SEMI))
                    begin
                        kind_hit = 1'b1; kind = kol_pkg::TK_BREAK; extra = 4'd4;
                    end
                CH_C:
                    if (kw_hit(cw, cfill, KW_CONTINUE, 4'd8, 1'b1, kol_pkg::CH_SEMI))
                    begin
                        kind_hit = 1'b1; kind = kol_pkg::TK_CONTINUE; extra = 4'd7;
                    end
                default: ;
            endcase

            if (kind_hit)
            begin
                k_op       = kol_pkg::CMD_TOKEN;
                k_data     = {2'b00, kind};
                k_skip     = extra;
                k_nonempty = 1'b0;
                k_string   = 1'b0;
            end
            else if (start_comment)
            begin
                k_comment = 1'b1;
            end
            else if (!is_space(c))
            begin
                k_op   = kol_pkg::CMD_PUSH;
                k_data = c;
                if (!nonempty_reg)
                    k_string = (c == kol_pkg::CH_QUOTE);
                k_nonempty = 1'b1;
            end
        end
    end

    // Handshake and command issue
    assign full        = (state_reg != F_IDLE) || ((fill_reg == 4'd8) && cmd_full);
    assign accept      = push && !full;
    assign final_front = (state_reg == F_DRAIN) && (fill_reg == 4'd1);
    assign proc        = (state_reg == F_IDLE)
                         ? (accept && !end_of_text && (fill_reg == 4'd8))
                         : !cmd_full;
    assign cmd_push    = proc && ((k_op != kol_pkg::CMD_NOP) || final_front);

    always_comb
    begin
        cmd.op       = k_op;
        cmd.data     = k_data;
        cmd.step_end = (state_reg == F_IDLE) || final_front;
        cmd.drop     = final_front;
    end

    // Advance window and classifier state
    always_comb
    begin
        state_next    = state_reg;
        win_next      = win_reg;
        fill_next     = fill_reg;
        skip_next     = skip_reg;
        comment_next  = comment_reg;
        nonempty_next = nonempty_reg;
        string_next   = string_reg;

        if (proc)
        begin
            for (int i = 0; i < kol_pkg::WINDOW_BYTES - 1; i++)
                win_next[i] = cw[i + 1];
            win_next[8]   = 8'd0;
            skip_next     = k_skip;
            comment_next  = k_comment;
            nonempty_next = k_nonempty;
            string_next   = k_string;
            if (state_reg == F_DRAIN)
                fill_next = fill_reg - 4'd1;
            if (final_front)
            begin
                state_next    = F_IDLE;
                skip_next     = 4'd0;
                comment_next  = 1'b0;
                nonempty_next = 1'b0;
                string_next   = 1'b0;
            end
        end
        else if (accept)
        begin
            win_next[fill_reg] = source_byte;
            fill_next          = fill_reg + 4'd1;
            if (end_of_text)
                state_next = F_DRAIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            win_reg      <= '0;
            fill_reg     <= 4'd0;
            skip_reg     <= 4'd0;
            comment_reg  <= 1'b0;
            nonempty_reg <= 1'b0;
            string_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            win_reg      <= win_next;
            fill_reg     <= fill_next;
            skip_reg     <= skip_next;
            comment_reg  <= comment_next;
            nonempty_reg <= nonempty_next;
            string_reg   <= string_next;
        end
    end

endmodule

/* rtl/kol_cmd_fifo.sv */
`include "assert_macros.svh"

module kol_cmd_fifo #(
    parameter int DEPTH = kol_pkg::CMDQ_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  kol_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output kol_pkg::cmd_t rd_data,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kol_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the word
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    `KOL_NEVER(a_no_write_when_full, clk, rst_n, wr_en && full)
    `KOL_NEVER(a_no_read_when_empty, clk, rst_n, rd_en && empty)

endmodule

/* rtl/kol_back.sv */
`include "assert_macros.svh"

module kol_back #(
    parameter int MAX_IDENT = kol_pkg::MAX_IDENT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    input  kol_pkg::cmd_t cmd,
    output logic          empty,
    input  logic          pop,
    output logic [5:0]    token_kind,
    output logic [7:0]    char_value,
    output logic          ident_end,
    output logic          truncated,
    output logic          run_last
);

    localparam int LEN_W = $clog2(MAX_IDENT + 1);
    localparam int IDX_W = $clog2(MAX_IDENT);
    localparam int RW    = kol_pkg::RCNT_W;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_RD   = 3'd1;
    localparam logic [2:0] B_CHAR = 3'd2;
    localparam logic [2:0] B_TOK  = 3'd3;
    localparam logic [2:0] B_FIN  = 3'd4;

    typedef struct packed {
        logic [5:0] kind;
        logic [7:0] ch;
        logic       last_ch;
        logic       trunc;
    } res_t;

    logic [7:0]       ident_mem [MAX_IDENT];
    logic [7:0]       rd_data_reg;

    logic [2:0]       state_reg, state_next;
    kol_pkg::cmd_t    cmd_reg, cmd_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [RW-1:0]    cnt_reg, cnt_next;
    logic             pend_valid_reg, pend_valid_next;
    res_t             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg, out_next;
    logic             out_last_reg, out_last_next;

    logic             mem_we;
    logic             out_free;
    logic             out_load;
    logic             emit_req;
    logic             emit_ok;
    logic             room;
    logic             last_char;
    res_t             emit_res;

    assign out_free  = !out_valid_reg || pop;
    assign room      = cnt_reg < RW'(kol_pkg::MAX_RESULTS);
    assign emit_ok   = !room || !pend_valid_reg || out_free;
    assign last_char = (idx_reg + LEN_W'(1)) == len_reg;

    // Sequence commands: append, flush the buffer, emit tokens, close steps
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;
        mem_we          = 1'b0;
        cmd_pop         = 1'b0;
        emit_req        = 1'b0;
        emit_res        = '0;

        case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    case (cmd.op)
                        kol_pkg::CMD_PUSH, kol_pkg::CMD_PUSH_FLUSH:
                        begin
                            if (len_reg < LEN_W'(MAX_IDENT))
                            begin
                                mem_we   = 1'b1;
                                len_next = len_reg + LEN_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            if (cmd.op == kol_pkg::CMD_PUSH_FLUSH)
                            begin
                                idx_next   = '0;
                                state_next = B_RD;
                            end
                            else
                            begin
                                state_next = cmd.step_end ? B_FIN : B_IDLE;
                            end
                        end
                        kol_pkg::CMD_TOKEN:
                        begin
                            idx_next   = '0;
                            state_next = (len_reg != '0) ? B_RD : B_TOK;
                        end
                        default:
                        begin
                            state_next = cmd.step_end ? B_FIN : B_IDLE;
                        end
                    endcase
                end
            end
            B_RD:
            begin
                state_next = B_CHAR;
            end
            B_CHAR:
            begin
                emit_req         = 1'b1;
                emit_res.kind    = kol_pkg::TK_IDENT;
                emit_res.ch      = rd_data_reg;
                emit_res.last_ch = last_char;
                emit_res.trunc   = ovf_reg;
                if (emit_ok)
                begin
                    if (last_char)
                    begin
                        len_next = '0;
                        ovf_next = 1'b0;
                        if (cmd_reg.op == kol_pkg::CMD_TOKEN)
                            state_next = B_TOK;
                        else
                            state_next = cmd_reg.step_end ? B_FIN : B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = B_RD;
                    end
                end
            end
            B_TOK:
            begin
                emit_req      = 1'b1;
                emit_res.kind = cmd_reg.data[5:0];
                if (emit_ok)
                    state_next = cmd_reg.step_end ? B_FIN : B_IDLE;
            end
            B_FIN:
            begin
                // Close the step: the held word becomes the last of its run
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_load      = 1'b1;
                        out_next      = pend_reg;
                        out_last_next = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                    if (cmd_reg.drop)
                    begin
                        len_next = '0;
                        ovf_next = 1'b0;
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // Hold the newest word; release the one before it
        if (emit_req && emit_ok && room)
        begin
            cnt_next = cnt_reg + RW'(1);
            if (pend_valid_reg)
            begin
                out_load      = 1'b1;
                out_next      = pend_reg;
                out_last_next = 1'b0;
            end
            pend_next       = emit_res;
            pend_valid_next = 1'b1;
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // Identifier buffer: append at the fill point, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ident_mem[len_reg[IDX_W-1:0]] <= cmd.data;
        rd_data_reg <= ident_mem[idx_reg[IDX_W-1:0]];
    end

    assign empty      = !out_valid_reg;
    assign token_kind = out_reg.kind;
    assign char_value = out_reg.ch;
    assign ident_end  = out_reg.last_ch;
    assign truncated  = out_reg.trunc;
    assign run_last   = out_last_reg;

    `KOL_ASSERT(a_len_bound, clk, rst_n, len_reg <= LEN_W'(MAX_IDENT))
    `KOL_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= RW'(kol_pkg::MAX_RESULTS))
    `KOL_ASSERT(a_idx_in_buffer, clk, rst_n,
                (state_reg == B_RD || state_reg == B_CHAR) |-> idx_reg < len_reg)
    `KOL_NEVER(a_no_out_overwrite, clk, rst_n, out_load && !out_free)
    `KOL_ASSERT(a_fin_empties_hold, clk, rst_n,
                (state_reg == B_FIN && out_free) |=> !pend_valid_reg)

endmodule

/* tb/keyword_operator_lexer_top_test.sv */
`timescale 1ns / 1ps

module keyword_operator_lexer_top_test;

    localparam int IDENT_MAX   = kol_pkg::MAX_IDENT_DEF;
    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 5000;
    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        logic [5:0] kind;
        logic [7:0] ch;
        logic       ident_end;
        logic       truncated;
        logic       run_last;
    } lex_word_t;

    // Token predictor plus the store of words still owed by the block
    class lex_scoreboard;
        logic [7:0] window[kol_pkg::WINDOW_BYTES];
        logic [7:0] ident_chars[IDENT_MAX];
        int         fill;
        int         skip_left;
        int         ident_len;
        bit         in_comment;
        bit         ident_cut;
        lex_word_t  step_words[$];
        lex_word_t  expected_q[$];
        int         errors;
        int         words_checked;

        function new();
            foreach (window[i]) window[i] = 8'h00;
            foreach (ident_chars[i]) ident_chars[i] = 8'h00;
            fill = 0;
            skip_left = 0;
            ident_len = 0;
            in_comment = 0;
            ident_cut = 0;
            errors = 0;
            words_checked = 0;
        endfunction

        function bit is_space(logic [7:0] c);
            return c == kol_pkg::CH_SPACE || (c >= kol_pkg::CH_TAB && c <= kol_pkg::CH_CR);
        endfunction

        // Drop anything past the per-byte result limit
        function void emit(int kind, logic [7:0] ch, bit last_ch, bit cut);
            lex_word_t w;
            if (step_words.size() >= kol_pkg::MAX_RESULTS)
                return;
            w.kind = kind[5:0];
            w.ch = ch;
            w.ident_end = last_ch;
            w.truncated = cut;
            w.run_last = 1'b0;
            step_words.push_back(w);
        endfunction

        function void flush_ident();
            int k;
            for (k = 0; k < ident_len; k++)
                emit(kol_pkg::TK_IDENT, ident_chars[k], k + 1 == ident_len, ident_cut);
            ident_len = 0;
            ident_cut = 0;
        endfunction

        // Saturate at the buffer size and flag the cut
        function void append_char(logic [7:0] c);
            if (ident_len < IDENT_MAX)
            begin
                ident_chars[ident_len] = c;
                ident_len++;
            end
            else
                ident_cut = 1;
        endfunction

        // Keyword letters after the front byte, then whitespace or the alternate delimiter
        function bit word_delim(string w, int alt);
            int n;
            int k;
            logic [7:0] d;
            n = w.len();
            if (fill <= n || n >= kol_pkg::WINDOW_BYTES)
                return 0;
            for (k = 1; k < n; k++)
                if (window[k] != w[k])
                    return 0;
            d = window[n];
            return is_space(d) || (alt >= 0 && d == alt[7:0]);
        endfunction

        // Classify the oldest window byte
        function void advance_front();
            logic [7:0] c;
            int kind;
            int extra;
            int op_base;
            bit has_next;
            bit eq;
            c = window[0];
            kind = -1;
            extra = 0;
            op_base = -1;
            if (skip_left > 0)
            begin
                skip_left--;
                return;
            end
            if (in_comment)
            begin
                if (c == kol_pkg::CH_NL)
                    in_comment = 0;
                return;
            end
            if (ident_len != 0 && ident_chars[0] == kol_pkg::CH_QUOTE)
            begin
                append_char(c);
                if (c == kol_pkg::CH_QUOTE)
                    flush_ident();
                return;
            end
            has_next = fill > 1;
            eq = has_next && window[1] == kol_pkg::CH_EQ;
            case (c)
                kol_pkg::CH_EQ:     op_base = kol_pkg::TK_ASSIGN;
                kol_pkg::CH_LT:     op_base = kol_pkg::TK_LESS;
                kol_pkg::CH_GT:     op_base = kol_pkg::TK_GREATER;
                kol_pkg::CH_PLUS:   op_base = kol_pkg::TK_ADD;
                kol_pkg::CH_MINUS:  op_base = kol_pkg::TK_SUB;
                kol_pkg::CH_STAR:   op_base = kol_pkg::TK_MUL;
                kol_pkg::CH_PCT:    op_base = kol_pkg::TK_MOD;
                kol_pkg::CH_BANG:   op_base = kol_pkg::TK_NOT;
                kol_pkg::CH_SLASH:
                begin
                    if (has_next && window[1] == kol_pkg::CH_SLASH)
                        in_comment = 1;
                    else
                        op_base = kol_pkg::TK_DIV;
                end
                kol_pkg::CH_LPAREN: kind = kol_pkg::TK_LPAREN;
                kol_pkg::CH_RPAREN: kind = kol_pkg::TK_RPAREN;
                kol_pkg::CH_LBRACE: kind = kol_pkg::TK_LBRACE;
                kol_pkg::CH_RBRACE: kind = kol_pkg::TK_RBRACE;
                kol_pkg::CH_LSQ:    kind = kol_pkg::TK_LSQUARE;
                kol_pkg::CH_RSQ:    kind = kol_pkg::TK_RSQUARE;
                kol_pkg::CH_SEMI:   kind = kol_pkg::TK_SEMI;
                kol_pkg::CH_COLON:  kind = kol_pkg::TK_COLON;
                kol_pkg::CH_COMMA:  kind = kol_pkg::TK_COMMA;
                kol_pkg::CH_DOT:
                begin
                    kind = kol_pkg::TK_DOT;
                    if (has_next && window[1] == kol_pkg::CH_DOT)
                    begin
                        kind = kol_pkg::TK_RANGE;
                        extra = 1;
                    end
                end
                "v":
                begin
                    if (word_delim("var", -1))
                    begin
                        kind = kol_pkg::TK_VAR;
                        extra = 3;
                    end
                end
                "s":
                begin
                    if (word_delim("struct", -1))
                    begin
                        kind = kol_pkg::TK_STRUCT;
                        extra = 6;
                    end
                end
                "i":
                begin
                    if (word_delim("if", -1))
                    begin
                        kind = kol_pkg::TK_IF;
                        extra = 2;
                    end
                end
                "e":
                begin
                    if (word_delim("enum", -1))
                    begin
                        kind = kol_pkg::TK_ENUM;
                        extra = 4;
                    end
                    else if (word_delim("else", -1))
                    begin
                        kind = kol_pkg::TK_ELSE;
                        extra = 4;
                    end
                end
                "l":
                begin
                    if (word_delim("loop", int'(kol_pkg::CH_LBRACE)))
                    begin
                        kind = kol_pkg::TK_LOOP;
                        extra = 3;
                    end
                end
                "w":
                begin
                    if (word_delim("while", -1))
                    begin
                        kind = kol_pkg::TK_WHILE;
                        extra = 5;
                    end
                end
                "f":
                begin
                    if (word_delim("fn", -1))
                    begin
                        kind = kol_pkg::TK_FN;
                        extra = 2;
                    end
                end
                "r":
                begin
                    if (word_delim("return", int'(kol_pkg::CH_SEMI)))
                    begin
                        kind = kol_pkg::TK_RETURN;
                        extra = 5;
                    end
                end
                "b":
                begin
                    if (word_delim("break", int'(kol_pkg::CH_SEMI)))
                    begin
                        kind = kol_pkg::TK_BREAK;
                        extra = 4;
                    end
                end
                "c":
                begin
                    if (word_delim("continue", int'(kol_pkg::CH_SEMI)))
                    begin
                        kind = kol_pkg::TK_CONTINUE;
                        extra = 7;
                    end
                end
                default: ;
            endcase
            // Two-character operators swallow their '='
            if (op_base >= 0)
            begin
                kind = op_base + int'(eq);
                extra = int'(eq);
            end
            if (kind >= 0)
            begin
                if (ident_len != 0)
                    flush_ident();
                emit(kind, 8'h00, 0, 0);
                skip_left = extra;
            end
            else if (!in_comment && !is_space(c))
                append_char(c);
        endfunction

        // Take one accepted input word and queue the words it owes
        function void note_byte(logic [7:0] b, bit eot);
            int k;
            step_words.delete();
            if (fill >= kol_pkg::WINDOW_BYTES)
                fill = kol_pkg::WINDOW_BYTES - 1;
            window[fill] = b;
            fill++;
            while (fill >= kol_pkg::WINDOW_BYTES || (eot && fill > 0))
            begin
                advance_front();
                for (k = 0; k < kol_pkg::WINDOW_BYTES - 1; k++)
                    window[k] = window[k + 1];
                window[kol_pkg::WINDOW_BYTES - 1] = 8'h00;
                fill--;
                window[fill] = 8'h00;
            end
            // End of text: drop the trailing identifier and start clean
            if (eot)
            begin
                ident_len = 0;
                ident_cut = 0;
                in_comment = 0;
                skip_left = 0;
            end
            if (step_words.size() > 0)
                step_words[$].run_last = 1'b1;
            foreach (step_words[i])
                expected_q.push_back(step_words[i]);
        endfunction

        function void check_word(lex_word_t got);
            lex_word_t exp;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected word kind=%0d char=%02h end=%b trunc=%b last=%b",
                             $time, got.kind, got.ch, got.ident_end, got.truncated,
                             got.run_last);
                return;
            end
            exp = expected_q.pop_front();
            words_checked++;
            if (got !== exp)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: mismatch expected kind=%0d char=%02h end=%b trunc=%b",
                             $time, exp.kind, exp.ch, exp.ident_end, exp.truncated,
                             " last=%b, actual kind=%0d char=%02h end=%b trunc=%b last=%b",
                             exp.run_last, got.kind, got.ch, got.ident_end, got.truncated,
                             got.run_last);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       push        = 1'b0;
    logic [7:0] source_byte = 8'h00;
    logic       end_of_text = 1'b0;
    logic       pop         = 1'b0;
    logic       full;
    logic       empty;
    logic [5:0] token_kind;
    logic [7:0] char_value;
    logic       ident_end;
    logic       truncated;
    logic       run_last;

    lex_scoreboard sb;
    logic [7:0]    text_q[$];
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    bit            hold_req = 0;
    int            bytes_sent = 0;
    int            texts_sent = 0;
    int            idle_cycles = 0;

    string kw_names[11] = '{"fn", "var", "struct", "enum", "if", "else", "loop",
                            "while", "return", "break", "continue"};

    keyword_operator_lexer_top #(
        .MAX_IDENT(IDENT_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .source_byte(source_byte),
        .end_of_text(end_of_text),
        .empty(empty),
        .pop(pop),
        .token_kind(token_kind),
        .char_value(char_value),
        .ident_end(ident_end),
        .truncated(truncated),
        .run_last(run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one word, idling first at the current rate; return on a falling edge
    task automatic send_byte(input logic [7:0] b, input bit eot);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        source_byte <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_byte(b, eot);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Send the built text, end of text marked on its last byte
    task automatic send_text();
        int i;
        for (i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        texts_sent++;
    endtask

    function automatic void add_str(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic void add_pick(string s);
        text_q.push_back(s[$urandom_range(0, s.len() - 1)]);
    endfunction

    // Mostly well-formed source with random content, some noise bytes
    function automatic void build_text();
        int target;
        int roll;
        int n;
        int k;
        int len;
        text_q.delete();
        target = $urandom_range(12, 40);
        while (text_q.size() < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 22)
            begin
                n = $urandom_range(0, 10);
                add_str(kw_names[n]);
                k = $urandom_range(0, 9);
                if (k == 0)
                    add_pick("xyz_");
                else if (k < 5 && n >= 8)
                    text_q.push_back(kol_pkg::CH_SEMI);
                else if (k < 5 && n == 6)
                    text_q.push_back(kol_pkg::CH_LBRACE);
                else
                    add_pick(" \t\n ");
            end
            else if (roll < 40)
            begin
                add_pick("=<>+-*%!/");
                if ($urandom_range(0, 1))
                    text_q.push_back(kol_pkg::CH_EQ);
            end
            else if (roll < 52)
            begin
                if ($urandom_range(0, 5) == 0)
                    add_str("..");
                else
                    add_pick("(){}[];:,.");
            end
            else if (roll < 72)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40)
                                                  : $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    add_pick("abcdefghijklmnopqrstuvwxyz_0123456789");
            end
            else if (roll < 80)
                add_pick(" \t\n\r\v\f");
            else if (roll < 86)
            begin
                add_str("//");
                len = $urandom_range(0, 6);
                for (k = 0; k < len; k++)
                    add_pick("ab c=;");
                text_q.push_back(kol_pkg::CH_NL);
            end
            else if (roll < 93)
            begin
                text_q.push_back(kol_pkg::CH_QUOTE);
                len = $urandom_range(0, 8);
                for (k = 0; k < len; k++)
                    add_pick("ab c;=(");
                text_q.push_back(kol_pkg::CH_QUOTE);
            end
            else
                text_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        lex_word_t got;
        hold_left = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req = 0;
                hold_left = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= recv_stall_pct);
            @(posedge clk);
            if (pop && !empty)
            begin
                got = {token_kind, char_value, ident_end, truncated, run_last};
                sb.check_word(got);
            end
            @(negedge clk);
        end
    end

    // End the run if nothing moves on either side for too long
    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles, %0d words outstanding",
                 $time, STALL_LIMIT, sb.pending());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int phase;
        int phase_end;
        int send_pct[5];
        int recv_pct[5];
        send_pct = '{0, 57, 0, 24, 0};
        recv_pct = '{0, 0, 57, 24, 0};
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: keyword, compare with '=', comment, string with a space, range
        text_q.delete();
        add_str("if a<=b//c\n\"s t\"..x;");
        send_text();
        // Directed: extreme bytes, lone '=', keyword cut off by the end of text
        text_q.delete();
        text_q.push_back(8'hFF);
        text_q.push_back(8'h00);
        add_str("=else");
        send_text();

        // Random phases; long result hold-off at the start of the first
        for (phase = 0; phase < 5; phase++)
        begin
            send_idle_pct = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            if (phase == 0)
                hold_req = 1;
            phase_end = bytes_sent + 62;
            while (bytes_sent < phase_end)
            begin
                build_text();
                send_text();
            end
        end
        push <= 1'b0;

        // Drain, then allow for a late extra word
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Sent %0d source bytes in %0d texts; checked %0d result words.",
                 bytes_sent, texts_sent, sb.words_checked);
        $display("Phases: free flow, sender gaps, result stalls, both, plus a %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
